@@ hdl/sts_pkg.sv @@
`default_nettype none

package sts_pkg;

    // stored table sizes and default parameter values
    localparam int TABLE_STORED      = 31;
    localparam int SWEEP_STORED      = 8;
    localparam int TABLE_ENTRIES_DEF = 31;
    localparam int SWEEP_ENTRIES_DEF = 8;

    // field and datapath widths
    localparam int STEP_W   = 16;
    localparam int IDX_W    = 5;
    localparam int COARSE_W = 3;
    localparam int FINE_W   = 4;
    localparam int US_W     = 15;
    localparam int NS_W     = 25;
    localparam int SET_NS_W = 24;
    localparam int DIV_W    = 4;
    localparam int CYC_W    = 9;
    localparam int SCALE_W  = 17;
    localparam int QUOT_W   = 16;
    localparam int CNT_W    = 4;
    localparam int USTEP_W  = 10;
    localparam int PROD_W   = USTEP_W + FINE_W;

    // fine digit runs 0..FINE_TOP
    localparam logic [FINE_W-1:0] FINE_TOP = 4'd9;

    // converter setting table: screen time in ns, clock divisor, sample cycles
    localparam logic [SET_NS_W-1:0] SETTING_NS [0:TABLE_STORED-1] = '{
        24'd83810,   24'd167619,  24'd175238,  24'd251429,  24'd274286,  24'd335238,
        24'd350476,  24'd487619,  24'd525714,  24'd548571,  24'd700952,  24'd822857,
        24'd914286,  24'd975238,  24'd1097143, 24'd1158095, 24'd1401905, 24'd1462857,
        24'd1828571, 24'd1950476, 24'd2102857, 24'd2316190, 24'd2742857, 24'd2803810,
        24'd3474286, 24'd3657143, 24'd3718095, 24'd4632381, 24'd7436190, 24'd11154286,
        24'd14872381
    };

    localparam logic [DIV_W-1:0] SETTING_DIV [0:TABLE_STORED-1] = '{
        4'd2, 4'd4, 4'd2, 4'd6, 4'd2, 4'd8, 4'd4, 4'd2, 4'd6, 4'd4, 4'd2, 4'd6, 4'd2, 4'd4,
        4'd8, 4'd2, 4'd4, 4'd6, 4'd4, 4'd8, 4'd6, 4'd4, 4'd6, 4'd8, 4'd6, 4'd8, 4'd2, 4'd8,
        4'd4, 4'd6, 4'd8
    };

    localparam logic [CYC_W-1:0] SETTING_CYC [0:TABLE_STORED-1] = '{
        9'd3,   9'd3,   9'd15,  9'd3,   9'd28,  9'd3,   9'd15,  9'd56,  9'd15,  9'd28,
        9'd84,  9'd28,  9'd112, 9'd56,  9'd28,  9'd144, 9'd84,  9'd56,  9'd112, 9'd56,
        9'd84,  9'd144, 9'd112, 9'd84,  9'd144, 9'd112, 9'd480, 9'd144, 9'd480, 9'd480,
        9'd480
    };

    // sweep list in us, and one tenth of the gap to the next entry
    localparam logic [US_W-1:0] SWEEP_LO_US [0:SWEEP_STORED-1] = '{
        15'd100, 15'd200, 15'd500, 15'd1000, 15'd2000, 15'd5000, 15'd10000, 15'd20000
    };

    localparam logic [USTEP_W-1:0] SWEEP_TENTH_US [0:SWEEP_STORED-2] = '{
        10'd10, 10'd30, 10'd50, 10'd100, 10'd300, 10'd500, 10'd1000
    };

    function automatic logic [SET_NS_W-1:0] setting_ns(input logic [IDX_W-1:0] idx);
        logic [SET_NS_W-1:0] v;
        v = '0;
        if (int'(idx) < TABLE_STORED) v = SETTING_NS[idx];
        return v;
    endfunction

    function automatic logic [DIV_W-1:0] setting_div(input logic [IDX_W-1:0] idx);
        logic [DIV_W-1:0] v;
        v = '0;
        if (int'(idx) < TABLE_STORED) v = SETTING_DIV[idx];
        return v;
    endfunction

    function automatic logic [CYC_W-1:0] setting_cyc(input logic [IDX_W-1:0] idx);
        logic [CYC_W-1:0] v;
        v = '0;
        if (int'(idx) < TABLE_STORED) v = SETTING_CYC[idx];
        return v;
    endfunction

    // controller states, one-hot
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_TIME   = 6'b000010,
        S_NANO   = 6'b000100,
        S_SEARCH = 6'b001000,
        S_DIVIDE = 6'b010000,
        S_OUTPUT = 6'b100000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic calc_us;
        logic calc_ns;
        logic search;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic step_nonzero;
        logic search_done;
        logic div_last;
    } t_dp_status;

endpackage

`default_nettype wire

@@ hdl/sts_ctrl.sv @@
`default_nettype none

module sts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  sts_pkg::t_dp_status i_status,
    output sts_pkg::t_dp_cmd    o_cmd
);
    import sts_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // sequencing of one knob event
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_status.step_nonzero) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_TIME;
                end
            end
            S_TIME: begin
                o_cmd.calc_us = 1'b1;
                n_state       = S_NANO;
            end
            S_NANO: begin
                o_cmd.calc_ns = 1'b1;
                n_state       = S_SEARCH;
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_status.search_done) n_state = S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_OUTPUT;
            end
            S_OUTPUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // checks
    a_start_goes_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_status.step_nonzero) |=> (r_state == S_TIME))
        else $error("accepted step did not start the sequence");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while still held");

    a_load_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_out_valid)
        else $error("loaded result not presented");

    a_divide_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVIDE && i_status.div_last) |=> (r_state == S_OUTPUT))
        else $error("divider end not followed by output");

endmodule

`default_nettype wire

@@ hdl/sts_datapath.sv @@
`default_nettype none

module sts_datapath #(
    parameter int TABLE_ENTRIES = sts_pkg::TABLE_ENTRIES_DEF,
    parameter int SWEEP_ENTRIES = sts_pkg::SWEEP_ENTRIES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic signed [sts_pkg::STEP_W-1:0]     i_step,
    input  sts_pkg::t_dp_cmd                      i_cmd,
    output sts_pkg::t_dp_status                   o_status,
    output logic        [sts_pkg::COARSE_W-1:0]   o_coarse_index,
    output logic        [sts_pkg::FINE_W-1:0]     o_fine_step,
    output logic        [sts_pkg::US_W-1:0]       o_sweep_time_us,
    output logic        [sts_pkg::IDX_W-1:0]      o_table_index,
    output logic        [sts_pkg::DIV_W-1:0]      o_prescaler_divide,
    output logic        [sts_pkg::CYC_W-1:0]      o_sample_cycles,
    output logic        [sts_pkg::SCALE_W-1:0]    o_x_scale
);
    import sts_pkg::*;

    // parameters clamped between 2 and the stored table sizes
    localparam int TABLE_N = (TABLE_ENTRIES > TABLE_STORED) ? TABLE_STORED :
                             (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;
    localparam int SWEEP_N = (SWEEP_ENTRIES > SWEEP_STORED) ? SWEEP_STORED :
                             (SWEEP_ENTRIES < 2) ? 2 : SWEEP_ENTRIES;
    localparam logic [COARSE_W-1:0] COARSE_MAX  = COARSE_W'(SWEEP_N - 2);
    localparam logic [COARSE_W-1:0] COARSE_TOP  = COARSE_W'(SWEEP_STORED - 2);
    localparam logic [IDX_W-1:0]    TABLE_LIMIT = IDX_W'(TABLE_N);
    localparam logic [CNT_W-1:0]    CNT_LAST    = CNT_W'(QUOT_W - 1);
    localparam logic [NS_W-1:0]     NS_PER_US   = NS_W'(1000);

    logic [COARSE_W-1:0] r_coarse, n_coarse;
    logic [FINE_W-1:0]   r_fine, n_fine;
    logic [US_W-1:0]     r_t_us;
    logic [NS_W-1:0]     r_t_ns;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_entry;
    logic [NS_W-1:0]     r_rem;
    logic [QUOT_W-1:0]   r_quot;
    logic                r_sat;
    logic [CNT_W-1:0]    r_cnt;

    logic [COARSE_W-1:0] coarse_sel;
    logic [PROD_W-1:0]   us_offset;
    logic [US_W-1:0]     us_calc;
    logic [NS_W-1:0]     ns_at_idx;
    logic [IDX_W-1:0]    entry_idx;
    logic [NS_W-1:0]     ns_entry;
    logic                search_done;
    logic [NS_W:0]       rem_shift;
    logic [NS_W:0]       rem_diff;
    logic                quot_bit;

    // knob position update, holding at both ends
    always_comb begin
        n_coarse = r_coarse;
        n_fine   = r_fine;
        if (i_cmd.start) begin
            if (!i_step[STEP_W-1]) begin
                if (r_fine < FINE_TOP) begin
                    n_fine = r_fine + 1'b1;
                end else if (r_coarse < COARSE_MAX) begin
                    n_fine   = '0;
                    n_coarse = r_coarse + 1'b1;
                end
            end else begin
                if (r_fine != '0) begin
                    n_fine = r_fine - 1'b1;
                end else if (r_coarse != '0) begin
                    n_fine   = FINE_TOP;
                    n_coarse = r_coarse - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coarse <= '0;
            r_fine   <= '0;
        end else begin
            r_coarse <= n_coarse;
            r_fine   <= n_fine;
        end
    end

    // interpolated sweep time in us
    assign coarse_sel = (r_coarse > COARSE_TOP) ? COARSE_TOP : r_coarse;
    assign us_offset  = PROD_W'(SWEEP_TENTH_US[coarse_sel]) * PROD_W'(r_fine);
    assign us_calc    = SWEEP_LO_US[coarse_sel] + US_W'(us_offset);

    // table search ends at first entry >= sweep time or table end
    assign ns_at_idx   = NS_W'(setting_ns(r_idx));
    assign search_done = (r_idx >= TABLE_LIMIT) || (ns_at_idx >= r_t_ns);
    assign entry_idx   = r_idx - 1'b1;
    assign ns_entry    = NS_W'(setting_ns(entry_idx));

    // restoring division, one quotient bit a cycle
    assign rem_shift = {r_rem, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, r_t_ns};
    assign quot_bit  = ~rem_diff[NS_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_us) begin
            r_t_us <= us_calc;
        end
        if (i_cmd.calc_ns) begin
            r_t_ns <= NS_W'(r_t_us) * NS_PER_US;
        end
        if (i_cmd.search) begin
            if (!search_done) begin
                r_idx <= r_idx + 1'b1;
            end else begin
                r_entry <= entry_idx;
                r_rem   <= ns_entry;
                r_sat   <= (ns_entry >= r_t_ns);
                r_cnt   <= '0;
            end
        end else if (i_cmd.calc_ns) begin
            r_idx <= IDX_W'(1);
        end
        if (i_cmd.div_step) begin
            r_rem  <= quot_bit ? rem_diff[NS_W-1:0] : rem_shift[NS_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], quot_bit};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_coarse_index     <= r_coarse;
            o_fine_step        <= r_fine;
            o_sweep_time_us    <= r_t_us;
            o_table_index      <= r_entry;
            o_prescaler_divide <= setting_div(r_entry);
            o_sample_cycles    <= setting_cyc(r_entry);
            o_x_scale          <= r_sat ? {1'b1, {QUOT_W{1'b0}}} : {1'b0, r_quot};
        end
    end

    // status back to the controller
    assign o_status.step_nonzero = (i_step != '0);
    assign o_status.search_done  = search_done;
    assign o_status.div_last     = (r_cnt == CNT_LAST);

    // checks
    a_fine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fine <= FINE_TOP)
        else $error("fine digit out of range");

    a_coarse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_coarse <= COARSE_MAX)
        else $error("coarse index beyond its limit");

    a_search_from_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.search |-> (r_idx != '0))
        else $error("search index at zero");

endmodule

`default_nettype wire

@@ hdl/scope_timebase_selector.sv @@
`default_nettype none

// Timebase knob for a scope front end. Each beat on the input carries a signed
// knob step; zero is taken and dropped, any other value moves the coarse/fine
// position one notch up or down (holding at both ends) and yields one result
// beat: the position, the interpolated sweep time in us, the chosen converter
// setting (index, clock divisor, sample cycles) and the x scale in unsigned
// Q1.16. A nonzero step runs from accept through the sweep time in us, its
// value in ns, a serial search of the setting table and a bit-serial divider
// for the x scale to the result; the next step is taken once the result
// sits in the output register, which holds it until the consumer takes it.
module scope_timebase_selector #(
    parameter int TABLE_ENTRIES = sts_pkg::TABLE_ENTRIES_DEF,
    parameter int SWEEP_ENTRIES = sts_pkg::SWEEP_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [sts_pkg::STEP_W-1:0]   i_step,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic        [sts_pkg::COARSE_W-1:0] o_coarse_index,
    output logic        [sts_pkg::FINE_W-1:0]   o_fine_step,
    output logic        [sts_pkg::US_W-1:0]     o_sweep_time_us,
    output logic        [sts_pkg::IDX_W-1:0]    o_table_index,
    output logic        [sts_pkg::DIV_W-1:0]    o_prescaler_divide,
    output logic        [sts_pkg::CYC_W-1:0]    o_sample_cycles,
    output logic        [sts_pkg::SCALE_W-1:0]  o_x_scale
);
    import sts_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer
    sts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // position, sweep time, search and divider
    sts_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SWEEP_ENTRIES (SWEEP_ENTRIES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (i_step),
        .i_cmd              (dp_cmd),
        .o_status           (dp_status),
        .o_coarse_index     (o_coarse_index),
        .o_fine_step        (o_fine_step),
        .o_sweep_time_us    (o_sweep_time_us),
        .o_table_index      (o_table_index),
        .o_prescaler_divide (o_prescaler_divide),
        .o_sample_cycles    (o_sample_cycles),
        .o_x_scale          (o_x_scale)
    );

endmodule

`default_nettype wire
